[rtl/nog_pkg.sv]
// Package for the neighbourhood offset generator: widths, constants, state codes.
`timescale 1ns / 1ps
package nog_pkg;

  localparam int MAX_DIMS   = 3;
  localparam int MAX_EXTENT = 1024;
  localparam int MAX_SIZE   = 64;

  localparam int WIDTH_W  = 7;   // requested kernel width
  localparam int EXTR_W   = 6;   // extreme value (width / 2)
  localparam int REL_W    = 7;   // signed relative coordinate
  localparam int EXT_W    = 11;  // array extent register
  localparam int NDIM_W   = 2;   // num_dims register
  localparam int OFS_W    = 27;  // linear offset
  localparam int SIZE_W   = 21;  // product of three widths
  localparam int STRIDE_W = 21;  // stride of dimension 2
  localparam int MUL_A_W  = 21;
  localparam int MUL_B_W  = 11;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

  localparam int IN_DATA_W  = 24;  // three widths, padded to bytes
  localparam int OUT_DATA_W = 48;  // three coordinates and the offset
  localparam int CFG_IDX_W  = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_DIM0 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_DIM1 = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIZE_AB,
    ST_SIZE_C,
    ST_STRIDE,
    ST_OFS_B,
    ST_OFS_C,
    ST_SETUP,
    ST_EMIT,
    ST_ERROR
  } state_t;

endpackage

[rtl/neighbourhood_offset_generator.sv]
// Top level of the neighbourhood offset generator: sequencer, shared multiplier, odometer.
`timescale 1ns / 1ps
//
// Usage:
//   A request enters on s_axis: three kernel widths, one per dimension. Even
//   widths round up to odd; dimensions at or above num_dims (min 1) count as 1.
//   The block then emits one item per neighbourhood position on m_axis, with
//   dimension 0 changing fastest; tlast marks the last position. If the
//   product of the rounded widths exceeds MAX_SIZE, a single item with tuser
//   (size error) and tlast set and all coordinates zero is emitted instead.
//   Configuration (num_dims, extent_dim0, extent_dim1) is written through
//   cfg_wr_en / cfg_index / cfg_data while the block is idle.
// Timing:
//   One shared 21x11 multiplier forms the size product, the dimension 2
//   stride and the start offset terms in SIZE_AB, SIZE_C, STRIDE, OFS_B and
//   OFS_C; SETUP loads the offset and deltas; EMIT then registers positions
//   one per cycle while m_axis is not stalled. s_axis_tready is high only
//   while the sequencer is idle, so no new request enters mid-neighbourhood.
// Reset: rst (synchronous) returns the sequencer to idle, empties the output
//   register and loads num_dims = 2, extents = 1024.
// Stall: a held m_axis_tready freezes the odometer; nothing is dropped.
//
module neighbourhood_offset_generator (
  input  logic                           clk,
  input  logic                           rst,
  // Input: width_a [6:0], width_b [13:7], width_c [20:14], zero [23:21]
  input  logic [nog_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Output: rel_a [6:0], rel_b [13:7], rel_c [20:14], linear_offset [47:21]
  output logic [nog_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Output tuser: size_error [0]
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Configuration write port
  input  logic                           cfg_wr_en,
  input  logic [nog_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nog_pkg::EXT_W-1:0]      cfg_data
);
  import nog_pkg::*;

  state_t state, state_next;

  // Configuration registers
  logic [NDIM_W-1:0] num_dims;
  logic [EXT_W-1:0]  extent_dim0;
  logic [EXT_W-1:0]  extent_dim1;

  // Per-request registers
  logic [WIDTH_W-1:0]       w_a, w_b, w_c;
  logic [EXTR_W-1:0]        extreme [3];
  logic signed [REL_W-1:0]  pos [3];
  logic [SIZE_W-1:0]        size_prod;
  logic [STRIDE_W-1:0]      stride2;
  logic [OFS_W-1:0]         ofs_b, ofs_c;
  logic [OFS_W-1:0]         delta1, delta2;
  logic [OFS_W-1:0]         offset;

  logic in_accept;
  logic out_free;
  logic is_last;

  // Saturated dimension 1 stride and extent, and effective dimension count
  logic [EXT_W-1:0]  stride1;
  logic [EXT_W-1:0]  ext1_sat;
  logic [NDIM_W-1:0] nd_eff;

  // Shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  // Rounded widths of the incoming request
  logic [WIDTH_W-1:0] in_w [3];

  // Odometer next values
  logic signed [REL_W-1:0] pos_next [3];
  logic [OFS_W-1:0]        offset_next;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  assign stride1  = (extent_dim0 > EXT_W'(MAX_EXTENT)) ? EXT_W'(MAX_EXTENT) : extent_dim0;
  assign ext1_sat = (extent_dim1 > EXT_W'(MAX_EXTENT)) ? EXT_W'(MAX_EXTENT) : extent_dim1;

  always_comb begin
    nd_eff = num_dims;
    if (num_dims == '0) nd_eff = NDIM_W'(1);
    if (num_dims > NDIM_W'(MAX_DIMS)) nd_eff = NDIM_W'(MAX_DIMS);
  end

  // Width rounding: unused dimensions are width 1, even widths become odd
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (i < int'(nd_eff)) begin
        in_w[i] = s_axis_tdata[i*WIDTH_W +: WIDTH_W] | WIDTH_W'(1);
      end else begin
        in_w[i] = WIDTH_W'(1);
      end
    end
  end

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SIZE_AB: begin
        mul_a = MUL_A_W'(w_a);
        mul_b = MUL_B_W'(w_b);
      end
      ST_SIZE_C: begin
        mul_a = size_prod;
        mul_b = MUL_B_W'(w_c);
      end
      ST_STRIDE: begin
        mul_a = MUL_A_W'(stride1);
        mul_b = ext1_sat;
      end
      ST_OFS_B: begin
        mul_a = MUL_A_W'(stride1);
        mul_b = MUL_B_W'(extreme[1]);
      end
      ST_OFS_C: begin
        mul_a = stride2;
        mul_b = MUL_B_W'(extreme[2]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // Last position when every coordinate sits at its upper extreme
  assign is_last = (pos[0] == $signed({1'b0, extreme[0]})) &&
                   (pos[1] == $signed({1'b0, extreme[1]})) &&
                   (pos[2] == $signed({1'b0, extreme[2]}));

  // Odometer step with incremental offset update
  always_comb begin
    for (int i = 0; i < 3; i++) pos_next[i] = pos[i];
    offset_next = offset;
    if (pos[0] < $signed({1'b0, extreme[0]})) begin
      pos_next[0] = pos[0] + REL_W'(1);
      offset_next = offset + OFS_W'(1);
    end else begin
      pos_next[0] = -$signed({1'b0, extreme[0]});
      if (pos[1] < $signed({1'b0, extreme[1]})) begin
        pos_next[1] = pos[1] + REL_W'(1);
        offset_next = offset + delta1;
      end else begin
        pos_next[1] = -$signed({1'b0, extreme[1]});
        pos_next[2] = pos[2] + REL_W'(1);
        offset_next = offset + delta2;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_accept) state_next = ST_SIZE_AB;
      ST_SIZE_AB: state_next = ST_SIZE_C;
      ST_SIZE_C:  state_next = (mul_p > MUL_P_W'(MAX_SIZE)) ? ST_ERROR : ST_STRIDE;
      ST_STRIDE:  state_next = ST_OFS_B;
      ST_OFS_B:   state_next = ST_OFS_C;
      ST_OFS_C:   state_next = ST_SETUP;
      ST_SETUP:   state_next = ST_EMIT;
      ST_EMIT:    if (out_free && is_last) state_next = ST_IDLE;
      ST_ERROR:   if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims    <= NDIM_W'(2);
      extent_dim0 <= EXT_W'(MAX_EXTENT);
      extent_dim1 <= EXT_W'(MAX_EXTENT);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NUM_DIMS:    num_dims    <= cfg_data[NDIM_W-1:0];
        REG_EXTENT_DIM0: extent_dim0 <= cfg_data;
        REG_EXTENT_DIM1: extent_dim1 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          w_a <= in_w[0];
          w_b <= in_w[1];
          w_c <= in_w[2];
          for (int i = 0; i < 3; i++) begin
            extreme[i] <= in_w[i][WIDTH_W-1:1];
            pos[i]     <= -$signed({1'b0, in_w[i][WIDTH_W-1:1]});
          end
        end
      end
      ST_SIZE_AB: size_prod <= mul_p[SIZE_W-1:0];
      ST_SIZE_C:  size_prod <= mul_p[SIZE_W-1:0];
      ST_STRIDE:  stride2   <= mul_p[STRIDE_W-1:0];
      ST_OFS_B:   ofs_b     <= mul_p[OFS_W-1:0];
      ST_OFS_C:   ofs_c     <= mul_p[OFS_W-1:0];
      ST_SETUP: begin
        offset <= OFS_W'(0) - OFS_W'(extreme[0]) - ofs_b - ofs_c;
        delta1 <= OFS_W'(stride1) - OFS_W'({extreme[0], 1'b0});
        delta2 <= OFS_W'(stride2) - OFS_W'({extreme[0], 1'b0})
                  - {ofs_b[OFS_W-2:0], 1'b0};
      end
      ST_EMIT: begin
        if (out_free && !is_last) begin
          pos    <= pos_next;
          offset <= offset_next;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == ST_EMIT || state == ST_ERROR) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      m_axis_tdata <= {offset, pos[2], pos[1], pos[0]};
      m_axis_tlast <= is_last;
      m_axis_tuser <= 1'b0;
    end else if (state == ST_ERROR && out_free) begin
      m_axis_tdata <= '0;
      m_axis_tlast <= 1'b1;
      m_axis_tuser <= 1'b1;
    end
  end

  // Checks
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> (pos[0] <= $signed({1'b0, extreme[0]})) &&
                         (pos[1] <= $signed({1'b0, extreme[1]})) &&
                         (pos[2] <= $signed({1'b0, extreme[2]})))
    else $error("odometer coordinate beyond extreme");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("size error item not a single zero item");

  a_error_size: assert property (@(posedge clk) disable iff (rst)
    state == ST_ERROR |-> size_prod > SIZE_W'(MAX_SIZE))
    else $error("error path taken for a neighbourhood within limits");

  a_emit_size_ok: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> size_prod <= SIZE_W'(MAX_SIZE))
    else $error("emitting an oversize neighbourhood");

endmodule
